@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

@@ src/b64c_pkg.sv @@
`timescale 1ns / 1ps

package b64c_pkg;

	localparam int BURST_MAX = 6;
	localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] MIN_LINE_LEN = 8'd4;
	localparam logic [7:0] LINE_LEN_RESET = 8'd76;

	typedef enum logic [1:0] {
		REG_MODE = 2'd0,
		REG_WRAP_ENABLE = 2'd1,
		REG_LINE_LENGTH = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	typedef enum logic {
		REQ_DATA = 1'b0,
		REQ_FINISH = 1'b1
	} req_t;

	typedef struct packed {
		mode_t mode;
		logic wrap_enable;
		logic [7:0] line_length;
		logic clear;
	} cfg_t;

	typedef struct packed {
		logic [BURST_CNT_W-1:0] cnt;
		logic [BURST_MAX-1:0][7:0] bytes;
	} burst_t;

	typedef struct packed {
		logic ok;
		logic [5:0] val;
	} sextet_t;

	// Alphabet character of a 6-bit value.
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) return w + 8'd65;
		else if (v < 6'd52) return w + 8'd71;
		else if (v < 6'd62) return w - 8'd4;
		else if (v == 6'd62) return CHAR_PLUS;
		else return CHAR_SLASH;
	endfunction

	// 6-bit value of an alphabet character; ok is low for anything else.
	function automatic sextet_t dec_char(input logic [7:0] c);
		sextet_t r;
		logic [7:0] t;
		r.ok = 1'b1;
		t = 8'd0;
		if (c inside {[8'h41:8'h5A]}) t = c - 8'd65;
		else if (c inside {[8'h61:8'h7A]}) t = c - 8'd71;
		else if (c inside {[8'h30:8'h39]}) t = c + 8'd4;
		else if (c == CHAR_PLUS) t = 8'd62;
		else if (c == CHAR_SLASH) t = 8'd63;
		else r.ok = 1'b0;
		r.val = t[5:0];
		return r;
	endfunction

endpackage

@@ src/b64c_core.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64c_core (
	input logic clk,
	input logic arst_n,
	input b64c_pkg::cfg_t cfg,
	input logic in_valid,
	output logic in_ready,
	input logic req_type,
	input logic [7:0] in_byte,
	input logic burst_free,
	output logic load,
	output b64c_pkg::burst_t burst
);

	logic vld_s1;
	logic req_s1;
	logic [7:0] byte_s1;
	logic consume;

	logic [23:0] grp_buf_q;
	logic [1:0] grp_cnt_q;
	logic [7:0] line_pos_q;

	logic [23:0] grp_buf_d;
	logic [1:0] grp_cnt_d;
	logic [7:0] line_pos_d;

	assign consume = vld_s1 && burst_free;
	assign in_ready = !vld_s1 || burst_free;
	assign load = consume && (burst.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= req_type;
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_buf_q <= '0;
			grp_cnt_q <= '0;
			line_pos_q <= '0;
		end else if (cfg.clear) begin
			grp_buf_q <= '0;
			grp_cnt_q <= '0;
			line_pos_q <= '0;
		end else if (consume) begin
			grp_buf_q <= grp_buf_d;
			grp_cnt_q <= grp_cnt_d;
			line_pos_q <= line_pos_d;
		end
	end

	always_comb begin
		logic [3:0][7:0] sym;
		logic emit4;
		logic [7:0] eff;
		logic [7:0] pos;
		logic [b64c_pkg::BURST_CNT_W-1:0] n;
		b64c_pkg::sextet_t dv;
		logic [23:0] nbuf;

		sym = '0;
		emit4 = 1'b0;
		eff = (cfg.line_length < b64c_pkg::MIN_LINE_LEN) ? b64c_pkg::MIN_LINE_LEN
			: cfg.line_length;
		pos = line_pos_q;
		n = '0;
		dv = b64c_pkg::dec_char(byte_s1);
		nbuf = grp_buf_q;
		grp_buf_d = grp_buf_q;
		grp_cnt_d = grp_cnt_q;
		burst.bytes = '0;

		if (cfg.mode == b64c_pkg::MODE_ENC) begin
			if (req_s1 == b64c_pkg::REQ_DATA) begin
				case (grp_cnt_q)
					2'd0: nbuf = grp_buf_q | {byte_s1, 16'h0000};
					2'd1: nbuf = grp_buf_q | {8'h00, byte_s1, 8'h00};
					default: nbuf = grp_buf_q | {16'h0000, byte_s1};
				endcase
				if (grp_cnt_q == 2'd2) begin
					emit4 = 1'b1;
					sym[0] = b64c_pkg::enc_char(nbuf[23:18]);
					sym[1] = b64c_pkg::enc_char(nbuf[17:12]);
					sym[2] = b64c_pkg::enc_char(nbuf[11:6]);
					sym[3] = b64c_pkg::enc_char(nbuf[5:0]);
					grp_buf_d = '0;
					grp_cnt_d = '0;
				end else begin
					grp_buf_d = nbuf;
					grp_cnt_d = grp_cnt_q + 2'd1;
				end
			end else begin
				emit4 = (grp_cnt_q != 2'd0);
				sym[0] = b64c_pkg::enc_char(grp_buf_q[23:18]);
				sym[1] = b64c_pkg::enc_char(grp_buf_q[17:12]);
				sym[2] = (grp_cnt_q == 2'd2) ? b64c_pkg::enc_char(grp_buf_q[11:6])
					: b64c_pkg::CHAR_PAD;
				sym[3] = b64c_pkg::CHAR_PAD;
				grp_buf_d = '0;
				grp_cnt_d = '0;
			end

			if (emit4) begin
				for (int k = 0; k < 4; k++) begin
					burst.bytes[n] = sym[k];
					n = n + 1'b1;
					if (cfg.wrap_enable) begin
						if ({1'b0, pos} + 9'd1 >= {1'b0, eff}) begin
							burst.bytes[n] = b64c_pkg::CHAR_CR;
							burst.bytes[n + 1'b1] = b64c_pkg::CHAR_LF;
							n = n + 2'd2;
							pos = '0;
						end else begin
							pos = pos + 8'd1;
						end
					end else begin
						pos = '0;
					end
				end
			end
			if (req_s1 == b64c_pkg::REQ_FINISH) begin
				pos = '0;
			end
		end else begin
			if (req_s1 == b64c_pkg::REQ_DATA) begin
				if (dv.ok) begin
					case (grp_cnt_q)
						2'd0: nbuf = grp_buf_q | {dv.val, 18'h00000};
						2'd1: nbuf = grp_buf_q | {6'h00, dv.val, 12'h000};
						2'd2: nbuf = grp_buf_q | {12'h000, dv.val, 6'h00};
						default: nbuf = grp_buf_q | {18'h00000, dv.val};
					endcase
					if (grp_cnt_q == 2'd3) begin
						burst.bytes[0] = nbuf[23:16];
						burst.bytes[1] = nbuf[15:8];
						burst.bytes[2] = nbuf[7:0];
						n = 3'd3;
						grp_buf_d = '0;
						grp_cnt_d = '0;
					end else begin
						grp_buf_d = nbuf;
						grp_cnt_d = grp_cnt_q + 2'd1;
					end
				end
			end else begin
				burst.bytes[0] = grp_buf_q[23:16];
				burst.bytes[1] = grp_buf_q[15:8];
				case (grp_cnt_q)
					2'd2: n = 3'd1;
					2'd3: n = 3'd2;
					default: n = 3'd0;
				endcase
				grp_buf_d = '0;
				grp_cnt_d = '0;
				pos = '0;
			end
		end

		line_pos_d = pos;
		burst.cnt = n;
	end

	// An encode group is flushed as soon as its third byte lands.
	`ASSERT_IMPLIES(a_enc_cnt, clk, arst_n, cfg.mode == b64c_pkg::MODE_ENC, grp_cnt_q != 2'd3)

endmodule

@@ src/b64c_burst.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64c_burst (
	input logic clk,
	input logic arst_n,
	input logic load,
	input b64c_pkg::burst_t burst,
	output logic free,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic last
);

	logic [b64c_pkg::BURST_MAX-1:0][7:0] bytes_q;
	logic [b64c_pkg::BURST_CNT_W-1:0] cnt_q;

	assign out_valid = (cnt_q != '0);
	assign last = (cnt_q == 3'd1);
	assign out_byte = bytes_q[0];
	assign free = (cnt_q == '0) || (last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= burst.cnt;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= burst.bytes;
		end else if (out_valid && out_ready) begin
			for (int k = 0; k < b64c_pkg::BURST_MAX - 1; k++) begin
				bytes_q[k] <= bytes_q[k + 1];
			end
		end
	end

	`ASSERT_ALWAYS(a_cnt_range, clk, arst_n, cnt_q <= 3'(b64c_pkg::BURST_MAX))
	`ASSERT_IMPLIES(a_load_free, clk, arst_n, load, free)
	`ASSERT_NEXT(a_drain, clk, arst_n, cnt_q > 3'd1 && out_ready && !load, cnt_q == $past(cnt_q) - 3'd1)

endmodule

@@ src/base64_stream_codec.sv @@
`timescale 1ns / 1ps
// An accepted item is captured in the input register, and its results are loaded into
// the output register once that is free. Throughput: one item per cycle while items give
// no results and the output register is free; an item that gives k results holds the
// single output register until all k are taken (four to six per encoded group).
// Reset: arst_n clears the group state, the line position and all valid flags at once.

module base64_stream_codec (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic req_type,
	input logic [7:0] in_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [7:0] out_byte,
	output logic last,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [7:0] cfg_data
);

	b64c_pkg::mode_t mode_q;
	logic wrap_enable_q;
	logic [7:0] line_length_q;
	logic mode_write;

	b64c_pkg::cfg_t cfg;
	b64c_pkg::burst_t burst;
	logic load;
	logic burst_free;

	// Register writes are always taken; the user must keep the block idle whenever they arrive, unchecked.
	assign cfg_ready = 1'b1;
	assign mode_write = cfg_valid && (cfg_index == b64c_pkg::REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= b64c_pkg::MODE_ENC;
			wrap_enable_q <= 1'b0;
			line_length_q <= b64c_pkg::LINE_LEN_RESET;
		end else if (cfg_valid) begin
			case (b64c_pkg::cfg_idx_t'(cfg_index))
				b64c_pkg::REG_MODE: mode_q <= b64c_pkg::mode_t'(cfg_data[0]);
				b64c_pkg::REG_WRAP_ENABLE: wrap_enable_q <= cfg_data[0];
				b64c_pkg::REG_LINE_LENGTH: line_length_q <= cfg_data;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	// A mode write restarts the group and the line, whatever value it carries.
	assign cfg.mode = mode_q;
	assign cfg.wrap_enable = wrap_enable_q;
	assign cfg.line_length = line_length_q;
	assign cfg.clear = mode_write;

	// Input register plus group logic: one transaction is turned into a burst of up to
	// six bytes (four characters with at most one CR LF, or up to three decoded bytes).
	b64c_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.in_byte(in_byte),
		.burst_free(burst_free),
		.load(load),
		.burst(burst)
	);

	// Result register: hold the burst and advance one byte per output transaction. It
	// frees up in the same cycle that its last byte is taken, so the next burst follows
	// without a gap.
	b64c_burst u_burst (
		.clk(clk),
		.arst_n(arst_n),
		.load(load),
		.burst(burst),
		.free(burst_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last(last)
	);

endmodule

@@ bench/tb_base64_stream_codec.sv @@
`timescale 1ns / 1ps

module tb_base64_stream_codec;

	// Index 3 is not a register; writes to it must leave everything alone.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	// Give items that make no output (ignored characters, empty finishes)
	// time to retire.
	localparam int SETTLE_CYCLES = 12;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		b64c_pkg::req_t kind;
		logic [7:0] data;
	} codec_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = 1'b0;
	logic [7:0] in_byte = 8'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_byte;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'd0;

	// Items waiting to be offered, and output beats predicted but not yet seen.
	codec_item_t byte_feed[$];
	out_beat_t expected_stream[$];
	codec_item_t next_item;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int bad_results = 0;
	int cycle_count = 0;

	// Shadow of the codec: configuration and the partial group.
	b64c_pkg::mode_t cur_mode = b64c_pkg::MODE_ENC;
	logic wrap_on = 1'b0;
	logic [7:0] line_len = b64c_pkg::LINE_LEN_RESET;
	logic [23:0] grp = 24'd0;
	int grp_fill = 0;
	int line_pos = 0;
	int beats_made = 0;

	string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	int char_value[256];

	base64_stream_codec uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	task automatic push_beat(input logic [7:0] b);
		out_beat_t beat;
		beat.data = b;
		beat.last = 1'b0;
		expected_stream.push_back(beat);
		beats_made++;
	endtask

	// Send one character of encoded text and account for line wrapping.
	// Pad characters go through here too, so a padded group can end a line.
	task automatic push_text(input logic [7:0] ch);
		int eff;
		eff = (line_len < b64c_pkg::MIN_LINE_LEN) ? b64c_pkg::MIN_LINE_LEN : line_len;
		push_beat(ch);
		if (wrap_on) begin
			if (line_pos + 1 >= eff) begin
				push_beat(b64c_pkg::CHAR_CR);
				push_beat(b64c_pkg::CHAR_LF);
				line_pos = 0;
			end else begin
				line_pos = line_pos + 1;
			end
		end else begin
			line_pos = 0;
		end
	endtask

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		return b64_alphabet[v];
	endfunction

	// Compute the output beats of one accepted transaction and queue them.
	task automatic code_item(input b64c_pkg::req_t kind, input logic [7:0] b);
		int v;
		beats_made = 0;
		if (cur_mode == b64c_pkg::MODE_ENC) begin
			if (kind == b64c_pkg::REQ_DATA) begin
				grp = grp | ({16'd0, b} << (16 - 8 * grp_fill));
				grp_fill++;
				if (grp_fill == 3) begin
					push_text(sextet_char(grp[23:18]));
					push_text(sextet_char(grp[17:12]));
					push_text(sextet_char(grp[11:6]));
					push_text(sextet_char(grp[5:0]));
					grp = 24'd0;
					grp_fill = 0;
				end
			end else begin
				// Flush a partial group: zero-filled tail bits, then padding.
				if (grp_fill >= 1) begin
					push_text(sextet_char(grp[23:18]));
					push_text(sextet_char(grp[17:12]));
					if (grp_fill == 2)
						push_text(sextet_char(grp[11:6]));
					else
						push_text(b64c_pkg::CHAR_PAD);
					push_text(b64c_pkg::CHAR_PAD);
				end
				grp = 24'd0;
				grp_fill = 0;
				line_pos = 0;
			end
		end else begin
			if (kind == b64c_pkg::REQ_DATA) begin
				v = char_value[b];
				// Drop anything outside the alphabet, pad included.
				if (v >= 0) begin
					grp = grp | (24'(v) << (18 - 6 * grp_fill));
					grp_fill++;
					if (grp_fill == 4) begin
						push_beat(grp[23:16]);
						push_beat(grp[15:8]);
						push_beat(grp[7:0]);
						grp = 24'd0;
						grp_fill = 0;
					end
				end
			end else begin
				// n values left over give n-1 bytes; a single value gives none.
				if (grp_fill >= 2)
					push_beat(grp[23:16]);
				if (grp_fill >= 3)
					push_beat(grp[15:8]);
				grp = 24'd0;
				grp_fill = 0;
				line_pos = 0;
			end
		end
		if (beats_made > 0)
			expected_stream[expected_stream.size() - 1].last = 1'b1;
	endtask

	task automatic apply_reg(input logic [1:0] idx, input logic [7:0] val);
		case (idx)
			b64c_pkg::REG_MODE: begin
				// Any mode write throws away the partial group and line position.
				cur_mode = b64c_pkg::mode_t'(val[0]);
				grp = 24'd0;
				grp_fill = 0;
				line_pos = 0;
			end
			b64c_pkg::REG_WRAP_ENABLE: begin
				wrap_on = val[0];
			end
			b64c_pkg::REG_LINE_LENGTH: begin
				line_len = val;
			end
			default: begin
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Input driver: offer queued items, holding each until it is taken
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= 1'b0;
			in_byte <= 8'd0;
		end else begin
			if (in_valid && in_ready)
				code_item(b64c_pkg::req_t'(req_type), in_byte);
			// Advance only when nothing is held on the bus.
			if (!in_valid || in_ready) begin
				if (byte_feed.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_item = byte_feed.pop_front();
					in_valid <= 1'b1;
					req_type <= next_item.kind;
					in_byte <= next_item.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: check each transaction against the oldest prediction
	// ------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_stream.size() == 0) begin
					if (bad_results < REPORT_MAX)
						$display("%0t: unexpected output out_byte=%h last=%b",
							$time, out_byte, last);
					bad_results++;
				end else if (expected_stream[0].data !== out_byte
						|| expected_stream[0].last !== last) begin
					if (bad_results < REPORT_MAX)
						$display("%0t: mismatch out_byte exp %h got %h, last exp %b got %b",
							$time, expected_stream[0].data, out_byte,
							expected_stream[0].last, last);
					bad_results++;
					void'(expected_stream.pop_front());
				end else begin
					void'(expected_stream.pop_front());
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a hung handshake or a missing output ends the run here.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------

	// Hold the write until the block takes it, then drop valid for a cycle so
	// back-to-back writes never raise and lower valid in one step.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Single-bit registers get random upper bits, which the block must ignore.
	task automatic configure(input b64c_pkg::mode_t m, input logic wrap,
			input logic [7:0] ll);
		logic [7:0] v;
		v = $urandom_range(255);
		v[0] = m;
		write_reg(b64c_pkg::REG_MODE, v);
		v = $urandom_range(255);
		v[0] = wrap;
		write_reg(b64c_pkg::REG_WRAP_ENABLE, v);
		write_reg(b64c_pkg::REG_LINE_LENGTH, ll);
	endtask

	task automatic queue_item(input b64c_pkg::req_t kind, input logic [7:0] b);
		codec_item_t it;
		it.kind = kind;
		it.data = b;
		byte_feed.push_back(it);
	endtask

	// Wait until every item is taken and every predicted beat has come out.
	task automatic drain();
		while (byte_feed.size() != 0 || in_valid || expected_stream.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Decode traffic is mostly valid alphabet text with some pad and noise
	// mixed in; ignored characters do not count toward the item budget.
	task automatic queue_random(input int count, input int finish_pct);
		codec_item_t it;
		int made;
		int pick;
		made = 0;
		while (made < count) begin
			it.data = $urandom_range(255);
			pick = $urandom_range(99);
			if (pick < finish_pct) begin
				it.kind = b64c_pkg::REQ_FINISH;
			end else begin
				it.kind = b64c_pkg::REQ_DATA;
				if (cur_mode == b64c_pkg::MODE_DEC) begin
					if (pick < 80)
						it.data = b64_alphabet[$urandom_range(63)];
					else if (pick < 88)
						it.data = b64c_pkg::CHAR_PAD;
				end
			end
			byte_feed.push_back(it);
			if (cur_mode == b64c_pkg::MODE_ENC || it.kind == b64c_pkg::REQ_FINISH
					|| char_value[it.data] >= 0)
				made++;
		end
	endtask

	task automatic random_phase(input b64c_pkg::mode_t m, input logic wrap,
			input logic [7:0] ll, input int gap_pct, input int stall_pct,
			input int count, input int finish_pct);
		configure(m, wrap, ll);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		queue_random(count, finish_pct);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 256; i++)
			char_value[i] = -1;
		for (int i = 0; i < 64; i++)
			char_value[b64_alphabet[i]] = i;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Encode basics: extreme bytes, one-byte tail with double pad, empty finish.
		configure(b64c_pkg::MODE_ENC, 1'b0, b64c_pkg::LINE_LEN_RESET);
		queue_item(b64c_pkg::REQ_DATA, 8'hFF);
		queue_item(b64c_pkg::REQ_DATA, 8'h00);
		queue_item(b64c_pkg::REQ_DATA, 8'h80);
		queue_item(b64c_pkg::REQ_DATA, 8'h7F);
		queue_item(b64c_pkg::REQ_FINISH, 8'hFF);
		queue_item(b64c_pkg::REQ_FINISH, 8'h00);
		drain();

		// Line length below the minimum acts as four: a padded group fills the
		// line exactly and CR LF follows at once.
		configure(b64c_pkg::MODE_ENC, 1'b1, 8'd2);
		queue_item(b64c_pkg::REQ_DATA, 8'h4D);
		queue_item(b64c_pkg::REQ_DATA, 8'h61);
		queue_item(b64c_pkg::REQ_FINISH, 8'h55);
		queue_item(b64c_pkg::REQ_DATA, 8'h01);
		queue_item(b64c_pkg::REQ_DATA, 8'hFE);
		queue_item(b64c_pkg::REQ_DATA, 8'h3C);
		drain();

		// Decode: full group with both special characters, ignored pad and
		// noise, three-value tail, single-value tail, empty finish.
		configure(b64c_pkg::MODE_DEC, 1'b0, b64c_pkg::LINE_LEN_RESET);
		queue_item(b64c_pkg::REQ_DATA, "T");
		queue_item(b64c_pkg::REQ_DATA, b64c_pkg::CHAR_SLASH);
		queue_item(b64c_pkg::REQ_DATA, b64c_pkg::CHAR_PLUS);
		queue_item(b64c_pkg::REQ_DATA, "9");
		queue_item(b64c_pkg::REQ_DATA, b64c_pkg::CHAR_PAD);
		queue_item(b64c_pkg::REQ_DATA, "*");
		queue_item(b64c_pkg::REQ_DATA, "a");
		queue_item(b64c_pkg::REQ_DATA, "Z");
		queue_item(b64c_pkg::REQ_DATA, "0");
		queue_item(b64c_pkg::REQ_FINISH, 8'h00);
		queue_item(b64c_pkg::REQ_DATA, "z");
		queue_item(b64c_pkg::REQ_FINISH, 8'hAA);
		queue_item(b64c_pkg::REQ_FINISH, 8'h55);
		drain();

		// Random traffic across settings and handshake pressure.
		random_phase(b64c_pkg::MODE_ENC, 1'b0, b64c_pkg::LINE_LEN_RESET, 0, 0, 40, 10);
		random_phase(b64c_pkg::MODE_ENC, 1'b1, 8'd4, 85, 0, 50, 10);
		write_reg(REG_UNUSED, 8'hA5);
		random_phase(b64c_pkg::MODE_ENC, 1'b1, 8'd0, 0, 85, 40, 10);
		// No finishes, so the line runs past the longest length.
		random_phase(b64c_pkg::MODE_ENC, 1'b1, 8'd255, 20, 20, 200, 0);
		random_phase(b64c_pkg::MODE_DEC, 1'b0, b64c_pkg::LINE_LEN_RESET, 0, 0, 50, 8);
		random_phase(b64c_pkg::MODE_DEC, 1'b1, 8'd7, 85, 0, 40, 8);
		random_phase(b64c_pkg::MODE_ENC, 1'b1, 8'd13, 0, 85, 40, 10);
		random_phase(b64c_pkg::MODE_DEC, 1'b0, 8'd255, 20, 20, 40, 8);

		if (bad_results == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
